[hdl/date_time_set_editor_core_defines.svh]
// Assertion macros for the checker file dtse_checker.sv.
`ifndef DATE_TIME_SET_EDITOR_CORE_DEFINES_SVH
`define DATE_TIME_SET_EDITOR_CORE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define DTSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define DTSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/dtse_pkg.sv]
package dtse_pkg;

    localparam int NUM_FIELDS = 6;
    localparam int FIELD_W    = 7;
    localparam int SEL_W      = 3;
    localparam int REQ_W      = 2;
    localparam int KEY_W      = 3;
    localparam int TICK_W     = 16;
    localparam int LEN_W      = 5;

    localparam int YEAR_W   = 7;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    typedef logic [FIELD_W-1:0] t_field;
    typedef logic [SEL_W-1:0]   t_sel;
    typedef logic [TICK_W-1:0]  t_tick;
    typedef logic [LEN_W-1:0]   t_len;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK = 2'd0,
        REQ_KEY  = 2'd1,
        REQ_LOAD = 2'd2
    } t_req;

    typedef enum logic [KEY_W-1:0] {
        KEY_NONE = 3'd0,
        KEY_MODE = 3'd1,
        KEY_NEXT = 3'd2,
        KEY_UP   = 3'd3,
        KEY_DOWN = 3'd4
    } t_key;

    localparam t_sel F_YEAR   = 3'd0;
    localparam t_sel F_MONTH  = 3'd1;
    localparam t_sel F_DAY    = 3'd2;
    localparam t_sel F_HOUR   = 3'd3;
    localparam t_sel F_MINUTE = 3'd4;
    localparam t_sel F_SECOND = 3'd5;
    localparam t_sel SEL_LAST = 3'd5;

    localparam t_field YEAR_MAX   = 7'd99;
    localparam t_field MONTH_MAX  = 7'd12;
    localparam t_field HOUR_MAX   = 7'd23;
    localparam t_field MINUTE_MAX = 7'd59;
    localparam t_field FIELD_ONE  = 7'd1;
    localparam t_field FIELD_ZERO = 7'd0;

    localparam t_tick BLINK_RESET = 16'd500;

    // Days in a month; zero for a month code with no length.
    function automatic t_len month_len(input t_field month, input t_field year);
        t_len len;
        case (month) inside
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
            7'd2:    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

[hdl/date_time_set_editor_core.sv]
// Date and time setting editor.
// Input channel (i_in_valid / o_in_stall) carries one request per transfer:
// a millisecond tick, a key press, or a time load from the clock chip.
// Output channel (o_out_valid / i_out_stall) returns exactly one result per
// request: the six buffered fields, edit mode, the selected field, the
// blanking flag for blinking, and a one-result commit strobe raised when
// edit mode is left with the mode key.
// The user must write the blink interval through i_cfg_we / i_cfg_wdata only
// while idle; the block does not enforce it. Latency: the result of a request
// is valid the cycle after its transfer. Throughput: one request per cycle
// while not stalled; the update is small compares and increments between the
// state registers and the result register. A stalled result holds; the input
// stalls only while a result is waiting and the receiver stalls, so the next
// request is taken in the same cycle the waiting result leaves.
// Reset (synchronous, active low): fields cleared, show mode, field 0
// selected, blink flag and tick counter cleared, blink interval 500 ticks.
module date_time_set_editor_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [dtse_pkg::TICK_W-1:0]        i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [dtse_pkg::REQ_W-1:0]         i_req_type,
    input  logic [dtse_pkg::KEY_W-1:0]         i_key_code,
    input  logic [dtse_pkg::YEAR_W-1:0]        i_rtc_year,
    input  logic [dtse_pkg::MONTH_W-1:0]       i_rtc_month,
    input  logic [dtse_pkg::DAY_W-1:0]         i_rtc_day,
    input  logic [dtse_pkg::HOUR_W-1:0]        i_rtc_hour,
    input  logic [dtse_pkg::MINUTE_W-1:0]      i_rtc_minute,
    input  logic [dtse_pkg::SECOND_W-1:0]      i_rtc_second,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [dtse_pkg::YEAR_W-1:0]        o_year,
    output logic [dtse_pkg::MONTH_W-1:0]       o_month,
    output logic [dtse_pkg::DAY_W-1:0]         o_day,
    output logic [dtse_pkg::HOUR_W-1:0]        o_hour,
    output logic [dtse_pkg::MINUTE_W-1:0]      o_minute,
    output logic [dtse_pkg::SECOND_W-1:0]      o_second,
    output logic                               o_edit_mode,
    output logic [dtse_pkg::SEL_W-1:0]         o_selected_field,
    output logic                               o_blank_selected,
    output logic                               o_commit_to_rtc
);

    import dtse_pkg::*;

    t_field r_f [NUM_FIELDS];
    t_field n_f [NUM_FIELDS];
    logic   r_edit, n_edit;
    t_sel   r_sel, n_sel;
    logic   r_blink, n_blink;
    t_tick  r_tick, n_tick;
    t_tick  r_blink_ticks;
    logic   n_commit;

    logic   r_out_valid;
    t_field r_res_f [NUM_FIELDS];
    logic   r_res_edit;
    t_sel   r_res_sel;
    logic   r_res_blank;
    logic   r_res_commit;

    logic   in_xfer;
    t_tick  tick_inc;

    t_field inc [NUM_FIELDS];
    logic [FIELD_W:0] dec [NUM_FIELDS];
    t_field up_f [NUM_FIELDS];
    t_field dn_f [NUM_FIELDS];
    t_len   up_len, dn_len;
    t_field dn_day;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_xfer    = i_in_valid & ~o_in_stall;
    assign tick_inc   = r_tick + 16'd1;

    // Selected field stepped by one, both directions.
    always_comb begin
        for (int i = 0; i < NUM_FIELDS; i++) begin
            inc[i] = r_f[i] + {{(FIELD_W-1){1'b0}}, (r_sel == SEL_W'(i))};
            dec[i] = {1'b0, r_f[i]} - {{FIELD_W{1'b0}}, (r_sel == SEL_W'(i))};
        end
    end

    // Up key: wrap fields to their range; day only when the month has a length.
    always_comb begin
        up_f[F_YEAR]   = (inc[F_YEAR] > YEAR_MAX) ? FIELD_ZERO : inc[F_YEAR];
        up_f[F_MONTH]  = (inc[F_MONTH] > MONTH_MAX) ? FIELD_ONE : inc[F_MONTH];
        up_len         = month_len(up_f[F_MONTH], up_f[F_YEAR]);
        up_f[F_DAY]    = (up_len != '0 && inc[F_DAY] > {2'b00, up_len}) ? FIELD_ONE
                                                                         : inc[F_DAY];
        up_f[F_HOUR]   = (inc[F_HOUR] > HOUR_MAX) ? FIELD_ZERO : inc[F_HOUR];
        up_f[F_MINUTE] = (inc[F_MINUTE] > MINUTE_MAX) ? FIELD_ZERO : inc[F_MINUTE];
        up_f[F_SECOND] = (inc[F_SECOND] > MINUTE_MAX) ? FIELD_ZERO : inc[F_SECOND];
    end

    // Down key: underflow wraps to the range top; a day past month end goes to 1.
    always_comb begin
        dn_f[F_YEAR]   = dec[F_YEAR][FIELD_W] ? YEAR_MAX : dec[F_YEAR][FIELD_W-1:0];
        dn_f[F_MONTH]  = (dec[F_MONTH][FIELD_W] || dec[F_MONTH][FIELD_W-1:0] == FIELD_ZERO)
                         ? MONTH_MAX : dec[F_MONTH][FIELD_W-1:0];
        dn_len         = month_len(dn_f[F_MONTH], dn_f[F_YEAR]);
        dn_day         = dec[F_DAY][FIELD_W-1:0];
        if (dn_len == '0) begin
            dn_f[F_DAY] = dn_day;
        end else if (dec[F_DAY][FIELD_W] || dn_day == FIELD_ZERO) begin
            dn_f[F_DAY] = {2'b00, dn_len};
        end else if (dn_day > {2'b00, dn_len}) begin
            dn_f[F_DAY] = FIELD_ONE;
        end else begin
            dn_f[F_DAY] = dn_day;
        end
        dn_f[F_HOUR]   = dec[F_HOUR][FIELD_W] ? HOUR_MAX : dec[F_HOUR][FIELD_W-1:0];
        dn_f[F_MINUTE] = dec[F_MINUTE][FIELD_W] ? MINUTE_MAX : dec[F_MINUTE][FIELD_W-1:0];
        dn_f[F_SECOND] = dec[F_SECOND][FIELD_W] ? MINUTE_MAX : dec[F_SECOND][FIELD_W-1:0];
    end

    always_comb begin
        n_f      = r_f;
        n_edit   = r_edit;
        n_sel    = r_sel;
        n_blink  = r_blink;
        n_tick   = r_tick;
        n_commit = 1'b0;
        case (t_req'(i_req_type))
            REQ_TICK: begin
                if (tick_inc == r_blink_ticks) begin
                    n_tick  = '0;
                    n_blink = ~r_blink;
                end else begin
                    n_tick = tick_inc;
                end
            end
            REQ_KEY: begin
                if (t_key'(i_key_code) == KEY_MODE) begin
                    n_edit   = ~r_edit;
                    n_commit = r_edit;
                end else if (r_edit) begin
                    case (t_key'(i_key_code))
                        KEY_NEXT: n_sel = (r_sel == SEL_LAST) ? F_YEAR : r_sel + 3'd1;
                        KEY_UP:   n_f   = up_f;
                        KEY_DOWN: n_f   = dn_f;
                        default:  n_sel = r_sel;
                    endcase
                end
            end
            REQ_LOAD: begin
                if (!r_edit) begin
                    n_f[F_YEAR]   = i_rtc_year;
                    n_f[F_MONTH]  = FIELD_W'(i_rtc_month);
                    n_f[F_DAY]    = FIELD_W'(i_rtc_day);
                    n_f[F_HOUR]   = FIELD_W'(i_rtc_hour);
                    n_f[F_MINUTE] = FIELD_W'(i_rtc_minute);
                    n_f[F_SECOND] = FIELD_W'(i_rtc_second);
                end
            end
            default: n_commit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_FIELDS; i++) begin
                r_f[i] <= '0;
            end
            r_edit        <= 1'b0;
            r_sel         <= F_YEAR;
            r_blink       <= 1'b0;
            r_tick        <= '0;
            r_blink_ticks <= BLINK_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_blink_ticks <= i_cfg_wdata;
            end
            if (in_xfer) begin
                r_f     <= n_f;
                r_edit  <= n_edit;
                r_sel   <= n_sel;
                r_blink <= n_blink;
                r_tick  <= n_tick;
            end
            r_out_valid <= in_xfer | o_in_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_res_f      <= n_f;
            r_res_edit   <= n_edit;
            r_res_sel    <= n_sel;
            r_res_blank  <= n_edit & n_blink;
            r_res_commit <= n_commit;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_year           = r_res_f[F_YEAR][YEAR_W-1:0];
    assign o_month          = r_res_f[F_MONTH][MONTH_W-1:0];
    assign o_day            = r_res_f[F_DAY][DAY_W-1:0];
    assign o_hour           = r_res_f[F_HOUR][HOUR_W-1:0];
    assign o_minute         = r_res_f[F_MINUTE][MINUTE_W-1:0];
    assign o_second         = r_res_f[F_SECOND][SECOND_W-1:0];
    assign o_edit_mode      = r_res_edit;
    assign o_selected_field = r_res_sel;
    assign o_blank_selected = r_res_blank;
    assign o_commit_to_rtc  = r_res_commit;

endmodule

[hdl/dtse_checker.sv]
`include "date_time_set_editor_core_defines.svh"

module dtse_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               o_in_stall,
    input  logic                               o_out_valid,
    input  logic                               i_out_stall,
    input  logic [dtse_pkg::YEAR_W-1:0]        o_year,
    input  logic [dtse_pkg::DAY_W-1:0]         o_day,
    input  logic [dtse_pkg::SECOND_W-1:0]      o_second,
    input  logic                               o_edit_mode,
    input  logic [dtse_pkg::SEL_W-1:0]         o_selected_field,
    input  logic                               o_blank_selected,
    input  logic                               o_commit_to_rtc
);

    import dtse_pkg::*;

    // Stalled result holds.
    `DTSE_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_year) && $stable(o_day) && $stable(o_second) && $stable(o_edit_mode) && $stable(o_commit_to_rtc), "stalled result changed")

    // Every transfer in gives a result next cycle.
    `DTSE_ASSERT_NEXT(a_one_result, i_in_valid && !o_in_stall, o_out_valid, "transfer gave no result")

    `DTSE_ASSERT_NOW(a_commit_leaves, o_out_valid && o_commit_to_rtc, !o_edit_mode, "commit while still editing")

    `DTSE_ASSERT_NOW(a_blank_edit, o_out_valid && o_blank_selected, o_edit_mode && o_selected_field <= SEL_LAST, "blanking outside edit mode")

endmodule

bind date_time_set_editor_core dtse_checker u_dtse_checker (.*);
